[rtl/etsp_pkg.sv]
package etsp_pkg;

   localparam int MaxSectionBytes = 4096;
   localparam int Overhead        = 11 + 4;
   localparam int Trailer         = 4;
   localparam int EvHdrLen        = 12;
   localparam int HeaderEndPos    = 13;
   localparam int MaxResults      = 3;

   localparam logic [7:0] TAG_SHORT_EVT = 8'h4d;
   localparam logic [7:0] TAG_CONTENT   = 8'h54;
   localparam logic [7:0] TAG_RATING    = 8'h55;

   typedef enum logic [2:0] {
      KIND_HEADER = 3'd0,
      KIND_NAME   = 3'd1,
      KIND_DESC   = 3'd2,
      KIND_EXTRAS = 3'd3,
      KIND_ERROR  = 3'd4
   } kind_type;

   typedef logic [11:0][7:0] hdr_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] event_id;
      logic [15:0] start_mjd;
      logic [18:0] start_seconds;
      logic [18:0] duration_seconds;
      logic [2:0]  run_state;
      logic        scrambled;
      logic [7:0]  text_byte;
      logic [7:0]  content_code;
      logic [7:0]  age_rating;
      logic        text_last;
      logic        section_done;
   } rsp_type;

   function automatic logic [3:0] bcd_digit(input logic [3:0] v);
      return (v > 4'd9) ? 4'd9 : v;
   endfunction

   function automatic logic [6:0] bcd_pair(input logic [7:0] b);
      return 7'(bcd_digit(b[7:4]) * 7'd10) + 7'(bcd_digit(b[3:0]));
   endfunction

   function automatic logic [18:0] bcd_hms(input logic [7:0] h, input logic [7:0] m,
                                           input logic [7:0] s);
      return 19'(bcd_pair(h) * 19'd3600) + 19'(bcd_pair(m) * 19'd60) + 19'(bcd_pair(s));
   endfunction

   function automatic rsp_type make_rsp(input kind_type kind, input logic [7:0] text,
                                        input logic last, input logic done,
                                        input hdr_type hdr, input logic [7:0] content,
                                        input logic [7:0] rating);
      rsp_type r;
      r = '0;
      r.kind = kind;
      r.section_done = done;
      if (kind != KIND_ERROR) begin
         r.event_id         = {hdr[0], hdr[1]};
         r.start_mjd        = {hdr[2], hdr[3]};
         r.start_seconds    = bcd_hms(hdr[4], hdr[5], hdr[6]);
         r.duration_seconds = bcd_hms(hdr[7], hdr[8], hdr[9]);
         r.run_state        = hdr[10][7:5];
         r.scrambled        = hdr[10][4];
         r.text_byte        = text;
         r.text_last        = last;
         if (kind == KIND_EXTRAS) begin
            r.content_code = content;
            r.age_rating   = rating;
         end
      end
      return r;
   endfunction

endpackage

[rtl/event_table_section_parser.sv]
// Event information table section parser.
// Request channel (req_): one section byte per request, table id byte first,
// req_tuser high on that first byte. Any request with req_tuser high starts a
// new section and drops the one in progress without a result.
// Response channel (rsp_): event header, name byte, description byte, event
// extras and error records; rsp_tuser carries the kind, rsp_tlast marks the
// last record of a section.
// Records caused by an accepted request are registered into the result queue
// and offered in order. Throughput: one request per cycle while records drain
// one per cycle. A request can cause up to three records, and these wait in a
// four-entry result queue; req_tready drops while that queue holds more than
// one record, so a stalled receiver backs up into the request side and
// nothing is lost.
// Reset: the parser returns to idle, ignoring bytes until a first byte, and
// the queue empties.
module event_table_section_parser
   import etsp_pkg::*;
#(
   parameter int MaxBytes = MaxSectionBytes
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,   // [7:0] section_byte
   input  logic          req_tuser,   // [0] first_byte
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // [15:0] event_id, [31:16] start_mjd, [50:32] start_seconds,
   // [69:51] duration_seconds, [72:70] run_state, [73] scrambled,
   // [81:74] text_byte, [89:82] content_code, [97:90] age_rating,
   // [98] text_last, [103:99] zero
   output logic [103:0]  rsp_tdata,
   output logic [2:0]    rsp_tuser,   // [2:0] kind
   output logic          rsp_tlast    // section_done
);

   logic                    accept;
   logic                    room;
   logic [1:0]              res_count;
   rsp_type [MaxResults-1:0] res;
   rsp_type                 head;

   assign req_tready = room;
   assign accept     = req_tvalid && room;

   etsp_parser #(
      .MaxBytes (MaxBytes)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_tdata),
      .first     (req_tuser),
      .res_count (res_count),
      .res       (res)
   );

   etsp_rsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (res_count),
      .push_data  (res),
      .room       (room),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (head)
   );

   // pack the head record, first field in the lowest bits
   assign rsp_tdata = {5'b00000, head.text_last, head.age_rating, head.content_code,
                       head.text_byte, head.scrambled, head.run_state,
                       head.duration_seconds, head.start_seconds, head.start_mjd,
                       head.event_id};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.section_done;

endmodule

[rtl/etsp_parser.sv]
module etsp_parser
   import etsp_pkg::*;
#(
   parameter int MaxBytes = MaxSectionBytes
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [7:0]              data_byte,
   input  logic                    first,
   output logic [1:0]              res_count,
   output rsp_type [MaxResults-1:0] res
);

   typedef enum logic [12:0] {
      PH_IDLE    = 13'b0000000000001,
      PH_LEN_HI  = 13'b0000000000010,
      PH_LEN_LO  = 13'b0000000000100,
      PH_HEADER  = 13'b0000000001000,
      PH_EVHDR   = 13'b0000000010000,
      PH_DTAG    = 13'b0000000100000,
      PH_DLEN    = 13'b0000001000000,
      PH_SKIP    = 13'b0000010000000,
      PH_LANG    = 13'b0000100000000,
      PH_NAMELEN = 13'b0001000000000,
      PH_NAME    = 13'b0010000000000,
      PH_TEXTLEN = 13'b0100000000000,
      PH_TEXT    = 13'b1000000000000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [11:0] pos_ff, pos_in;
   logic [11:0] sec_ff, sec_in;
   logic [11:0] loop_ff, loop_in;
   logic [7:0]  tag_ff, tag_in;
   logic [7:0]  drem_ff, drem_in;
   logic [7:0]  txt_ff, txt_in;
   logic        seen_ff, seen_in;
   logic [7:0]  content_ff, content_in;
   logic [7:0]  rating_ff, rating_in;
   hdr_type     hdr_ff, hdr_in;

   always_comb begin
      logic [11:0] len;
      logic [11:0] region;
      logic        desc_end_req, ev_end_req, begin_req, fail_req;
      len = '0;
      region = '0;
      desc_end_req = 1'b0;
      ev_end_req = 1'b0;
      begin_req = 1'b0;
      fail_req = 1'b0;
      phase_in = phase_ff;
      pos_in = pos_ff;
      sec_in = sec_ff;
      loop_in = loop_ff;
      tag_in = tag_ff;
      drem_in = drem_ff;
      txt_in = txt_ff;
      seen_in = seen_ff;
      content_in = content_ff;
      rating_in = rating_ff;
      hdr_in = hdr_ff;
      res_count = 2'd0;
      res = '0;

      if (accept && first) begin
         phase_in = PH_LEN_HI;
         pos_in = 12'd1;
         sec_in = '0;
      end else if (accept && phase_ff != PH_IDLE) begin
         pos_in = pos_ff + 12'd1;
         if (phase_ff != PH_LEN_HI && phase_ff != PH_LEN_LO && sec_ff != '0)
            sec_in = sec_ff - 12'd1;
         region = (sec_in > 12'(Trailer)) ? sec_in - 12'(Trailer) : '0;

         unique case (phase_ff)
            PH_LEN_HI: begin
               sec_in = {data_byte[3:0], 8'h00};
               phase_in = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               len = sec_ff | {4'h0, data_byte};
               if (len > 12'(MaxBytes - 3) || len <= 12'(Overhead)) begin
                  fail_req = 1'b1;
               end else begin
                  sec_in = len;
                  phase_in = PH_HEADER;
               end
            end
            PH_HEADER: begin
               if (pos_ff >= 12'(HeaderEndPos)) begin_req = 1'b1;
            end
            PH_EVHDR: begin
               if (txt_ff < 8'(EvHdrLen)) hdr_in[txt_ff[3:0]] = data_byte;
               txt_in = txt_ff + 8'd1;
               if (txt_in >= 8'(EvHdrLen)) begin
                  len = {hdr_in[10][3:0], hdr_in[11]};
                  if (len > region) begin
                     fail_req = 1'b1;
                  end else begin
                     loop_in = len;
                     res[res_count] = make_rsp(KIND_HEADER, 8'h00, 1'b0, 1'b0, hdr_in,
                                               content_in, rating_in);
                     res_count = res_count + 2'd1;
                     if (len == '0) ev_end_req = 1'b1;
                     else if (len < 12'd2) fail_req = 1'b1;
                     else phase_in = PH_DTAG;
                  end
               end
            end
            PH_DTAG: begin
               tag_in = data_byte;
               if (loop_ff != '0) loop_in = loop_ff - 12'd1;
               phase_in = PH_DLEN;
            end
            PH_DLEN: begin
               if (loop_ff != '0) loop_in = loop_ff - 12'd1;
               if ({4'h0, data_byte} > loop_in) begin
                  fail_req = 1'b1;
               end else begin
                  loop_in = loop_in - {4'h0, data_byte};
                  drem_in = data_byte;
                  txt_in = '0;
                  if (tag_ff == TAG_SHORT_EVT && !seen_ff) begin
                     if (data_byte < 8'd4) begin
                        fail_req = 1'b1;
                     end else begin
                        seen_in = 1'b1;
                        txt_in = 8'd3;
                        phase_in = PH_LANG;
                     end
                  end else if (data_byte == 8'h00) begin
                     desc_end_req = 1'b1;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
            end
            PH_SKIP: begin
               if (drem_ff != '0) drem_in = drem_ff - 8'd1;
               if (tag_ff == TAG_CONTENT && txt_ff == 8'd0 && content_ff == 8'h00)
                  content_in = data_byte;
               if (tag_ff == TAG_RATING && txt_ff == 8'd3 && rating_ff == 8'h00)
                  rating_in = data_byte;
               if (txt_ff != 8'hff) txt_in = txt_ff + 8'd1;
               if (drem_in == '0) desc_end_req = 1'b1;
            end
            PH_LANG: begin
               if (drem_ff != '0) drem_in = drem_ff - 8'd1;
               if (txt_ff != '0) txt_in = txt_ff - 8'd1;
               if (txt_in == '0) phase_in = PH_NAMELEN;
            end
            PH_NAMELEN: begin
               if (drem_ff != '0) drem_in = drem_ff - 8'd1;
               if ({1'b0, data_byte} + 9'd1 > {1'b0, drem_in}) begin
                  fail_req = 1'b1;
               end else begin
                  txt_in = data_byte;
                  phase_in = (data_byte == 8'h00) ? PH_TEXTLEN : PH_NAME;
               end
            end
            PH_NAME: begin
               if (drem_ff != '0) drem_in = drem_ff - 8'd1;
               if (txt_ff != '0) txt_in = txt_ff - 8'd1;
               res[res_count] = make_rsp(KIND_NAME, data_byte, txt_in == '0, 1'b0, hdr_in,
                                         content_in, rating_in);
               res_count = res_count + 2'd1;
               if (txt_in == '0) phase_in = PH_TEXTLEN;
            end
            PH_TEXTLEN: begin
               if (drem_ff != '0) drem_in = drem_ff - 8'd1;
               if (data_byte > drem_in) begin
                  fail_req = 1'b1;
               end else begin
                  txt_in = data_byte;
                  if (data_byte == 8'h00) begin
                     if (drem_in == '0) desc_end_req = 1'b1;
                     else begin
                        phase_in = PH_SKIP;
                        txt_in = '0;
                     end
                  end else begin
                     phase_in = PH_TEXT;
                  end
               end
            end
            PH_TEXT: begin
               if (drem_ff != '0) drem_in = drem_ff - 8'd1;
               if (txt_ff != '0) txt_in = txt_ff - 8'd1;
               res[res_count] = make_rsp(KIND_DESC, data_byte, txt_in == '0, 1'b0, hdr_in,
                                         content_in, rating_in);
               res_count = res_count + 2'd1;
               if (txt_in == '0) begin
                  if (drem_in == '0) desc_end_req = 1'b1;
                  else begin
                     phase_in = PH_SKIP;
                     txt_in = '0;
                  end
               end
            end
            default: phase_in = PH_IDLE;
         endcase

         // close a descriptor, then possibly the event, then open the next one
         if (desc_end_req) begin
            if (loop_in == '0) ev_end_req = 1'b1;
            else if (loop_in < 12'd2) fail_req = 1'b1;
            else phase_in = PH_DTAG;
         end
         if (ev_end_req) begin
            res[res_count] = make_rsp(KIND_EXTRAS, 8'h00, 1'b0, region == '0, hdr_in,
                                      content_in, rating_in);
            res_count = res_count + 2'd1;
            if (region == '0) phase_in = PH_IDLE;
            else begin_req = 1'b1;
         end
         if (begin_req) begin
            if (region < 12'(EvHdrLen)) begin
               fail_req = 1'b1;
            end else begin
               phase_in = PH_EVHDR;
               txt_in = '0;
               seen_in = 1'b0;
               content_in = '0;
               rating_in = '0;
            end
         end
         if (fail_req) begin
            res[res_count] = make_rsp(KIND_ERROR, 8'h00, 1'b0, 1'b1, hdr_in,
                                      content_in, rating_in);
            res_count = res_count + 2'd1;
            phase_in = PH_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         pos_ff <= '0;
         sec_ff <= '0;
         loop_ff <= '0;
         tag_ff <= '0;
         drem_ff <= '0;
         txt_ff <= '0;
         seen_ff <= 1'b0;
         content_ff <= '0;
         rating_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff <= pos_in;
         sec_ff <= sec_in;
         loop_ff <= loop_in;
         tag_ff <= tag_in;
         drem_ff <= drem_in;
         txt_ff <= txt_in;
         seen_ff <= seen_in;
         content_ff <= content_in;
         rating_ff <= rating_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff <= hdr_in;
   end

endmodule

[rtl/etsp_rsp_queue.sv]
module etsp_rsp_queue
   import etsp_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic [1:0]              push_count,
   input  rsp_type [MaxResults-1:0] push_data,
   output logic                    room,
   output logic                    out_valid,
   input  logic                    out_ready,
   output rsp_type                 out_data
);

   localparam int Depth = 4;

   rsp_type     mem [Depth];
   logic [1:0]  wr_ff, wr_in;
   logic [1:0]  rd_ff, rd_in;
   logic [2:0]  count_ff, count_in;
   logic        pop;

   // room for a full burst of results from one request
   assign room      = count_ff <= 3'(Depth - MaxResults);
   assign out_valid = count_ff != '0;
   assign out_data  = mem[rd_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in    = wr_ff + push_count;
      rd_in    = rd_ff + {1'b0, pop};
      count_in = count_ff + {1'b0, push_count} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MaxResults; i++) begin
         if (2'(i) < push_count) mem[wr_ff + 2'(i)] <= push_data[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

[rtl/etsp_checker.sv]
module etsp_checker
   import etsp_pkg::*;
(
   input logic          clock,
   input logic          reset,
   input logic          req_tready,
   input logic          rsp_tvalid,
   input logic          rsp_tready,
   input logic [103:0]  rsp_tdata,
   input logic [2:0]    rsp_tuser,
   input logic          rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_ERROR |-> rsp_tlast)
      else $error("error record does not close the section");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_ERROR |-> rsp_tdata == '0)
      else $error("error record carries event fields");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("records survive reset");

endmodule

bind event_table_section_parser etsp_checker u_etsp_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

[dv/event_table_section_parser_test.sv]
module event_table_section_parser_test;
   import etsp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Parser phases, in the order the section bytes walk through them.
   typedef enum int {
      P_IDLE, P_LEN_HI, P_LEN_LO, P_HEADER, P_EVHDR, P_DTAG, P_DLEN,
      P_SKIP, P_LANG, P_NAMELEN, P_NAME, P_TEXTLEN, P_TEXT
   } phase_type;

   typedef logic [7:0] byte_queue[$];

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [7:0]    req_tdata = '0;
   logic          req_tuser = 1'b0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [103:0]  rsp_tdata;
   logic [2:0]    rsp_tuser;
   logic          rsp_tlast;

   event_table_section_parser DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Records the parser owes us, oldest first.
   rsp_type   pending_records[$];
   int        mismatch_count = 0;
   int        request_count  = 0;
   int        record_count   = 0;
   int        section_count  = 0;
   int        error_count    = 0;
   bit        steady_flow    = 1'b0;   // when set, neither side idles

   // Parser state mirrored by the predictor.
   phase_type   phase = P_IDLE;
   logic [11:0] pos_count = '0;
   logic [11:0] sect_left = '0;
   logic [11:0] loop_left = '0;
   logic [11:0] evt_count = '0;
   logic [7:0]  hdr_bytes[12];
   logic [7:0]  desc_tag = '0;
   logic [7:0]  desc_left = '0;
   logic [7:0]  txt_left = '0;
   logic [2:0]  seen = '0;
   logic [7:0]  content_hold = '0;
   logic [7:0]  rating_hold = '0;

   function automatic int bcd_value(input logic [7:0] b);
      int hi, lo;
      hi = (b[7:4] > 9) ? 9 : b[7:4];
      lo = (b[3:0] > 9) ? 9 : b[3:0];
      return hi * 10 + lo;
   endfunction

   function automatic logic [18:0] hms_seconds(input int at);
      return 19'(bcd_value(hdr_bytes[at]) * 3600 + bcd_value(hdr_bytes[at + 1]) * 60
                 + bcd_value(hdr_bytes[at + 2]));
   endfunction

   function automatic int event_region();
      return (sect_left > Trailer) ? sect_left - Trailer : 0;
   endfunction

   // Queue one record built from the current event header.
   function automatic void push_record(input kind_type kind, input logic [7:0] text,
                                       input logic last, input logic done);
      rsp_type r;
      r = '0;
      r.kind = kind;
      r.section_done = done;
      if (kind != KIND_ERROR) begin
         r.event_id         = {hdr_bytes[0], hdr_bytes[1]};
         r.start_mjd        = {hdr_bytes[2], hdr_bytes[3]};
         r.start_seconds    = hms_seconds(4);
         r.duration_seconds = hms_seconds(7);
         r.run_state        = hdr_bytes[10][7:5];
         r.scrambled        = hdr_bytes[10][4];
         r.text_byte        = text;
         r.text_last        = last;
         if (kind == KIND_EXTRAS) begin
            r.content_code = content_hold;
            r.age_rating   = rating_hold;
         end
      end
      pending_records.push_back(r);
   endfunction

   function automatic void abort_section();
      push_record(KIND_ERROR, 8'h00, 1'b0, 1'b1);
      phase = P_IDLE;
   endfunction

   function automatic void open_event();
      if (event_region() < EvHdrLen) begin
         abort_section();
         return;
      end
      phase = P_EVHDR;
      txt_left = '0;
      seen = '0;
      content_hold = '0;
      rating_hold = '0;
   endfunction

   function automatic void close_event();
      bit last_event;
      last_event = (event_region() == 0);
      push_record(KIND_EXTRAS, 8'h00, 1'b0, last_event);
      if (last_event) phase = P_IDLE;
      else open_event();
   endfunction

   function automatic void close_descriptor();
      if (loop_left == 0) close_event();
      else if (loop_left < 2) abort_section();
      else phase = P_DTAG;
   endfunction

   function automatic void finish_text();
      if (desc_left == 0) begin
         close_descriptor();
      end else begin
         phase = P_SKIP;
         txt_left = '0;
      end
   endfunction

   // Advance the mirrored parser by one accepted request.
   function automatic void predict_byte(input logic [7:0] b, input logic first);
      int p, n;
      if (first) begin
         phase = P_LEN_HI;
         pos_count = 12'd1;
         sect_left = '0;
         evt_count = '0;
         return;
      end
      if (phase == P_IDLE) return;
      p = pos_count;
      pos_count = pos_count + 12'd1;
      if (phase >= P_HEADER && sect_left > 0) sect_left = sect_left - 12'd1;
      case (phase)
         P_LEN_HI: begin
            sect_left = {b[3:0], 8'h00};
            phase = P_LEN_LO;
         end
         P_LEN_LO: begin
            n = {sect_left[11:8], b};
            if (n > MaxSectionBytes - 3 || n <= Overhead) abort_section();
            else begin
               sect_left = 12'(n);
               phase = P_HEADER;
            end
         end
         P_HEADER: if (p >= HeaderEndPos) open_event();
         P_EVHDR: begin
            if (txt_left < EvHdrLen) hdr_bytes[txt_left] = b;
            txt_left = txt_left + 8'd1;
            if (txt_left >= EvHdrLen) begin
               n = {hdr_bytes[10][3:0], hdr_bytes[11]};
               if (n > event_region()) begin
                  abort_section();
                  return;
               end
               if (evt_count < 12'hfff) evt_count = evt_count + 12'd1;
               loop_left = 12'(n);
               push_record(KIND_HEADER, 8'h00, 1'b0, 1'b0);
               if (n == 0) close_event();
               else if (n < 2) abort_section();
               else phase = P_DTAG;
            end
         end
         P_DTAG: begin
            desc_tag = b;
            if (loop_left > 0) loop_left = loop_left - 12'd1;
            phase = P_DLEN;
         end
         P_DLEN: begin
            if (loop_left > 0) loop_left = loop_left - 12'd1;
            if (b > loop_left) begin
               abort_section();
               return;
            end
            loop_left = loop_left - {4'h0, b};
            desc_left = b;
            txt_left = '0;
            if (desc_tag == TAG_SHORT_EVT && !seen[0]) begin
               if (b < 4) begin
                  abort_section();
                  return;
               end
               seen[0] = 1'b1;
               txt_left = 8'd3;
               phase = P_LANG;
            end else if (b == 0) close_descriptor();
            else phase = P_SKIP;
         end
         P_SKIP: begin
            if (desc_left > 0) desc_left = desc_left - 8'd1;
            if (desc_tag == TAG_CONTENT && txt_left == 0 && content_hold == 0)
               content_hold = b;
            if (desc_tag == TAG_RATING && txt_left == 3 && rating_hold == 0)
               rating_hold = b;
            if (txt_left < 8'hff) txt_left = txt_left + 8'd1;
            if (desc_left == 0) close_descriptor();
         end
         P_LANG: begin
            if (desc_left > 0) desc_left = desc_left - 8'd1;
            if (txt_left > 0) txt_left = txt_left - 8'd1;
            if (txt_left == 0) phase = P_NAMELEN;
         end
         P_NAMELEN: begin
            if (desc_left > 0) desc_left = desc_left - 8'd1;
            if (int'(b) + 1 > desc_left) begin
               abort_section();
               return;
            end
            txt_left = b;
            phase = (b == 0) ? P_TEXTLEN : P_NAME;
         end
         P_NAME: begin
            if (desc_left > 0) desc_left = desc_left - 8'd1;
            if (txt_left > 0) txt_left = txt_left - 8'd1;
            push_record(KIND_NAME, b, txt_left == 0, 1'b0);
            if (txt_left == 0) phase = P_TEXTLEN;
         end
         P_TEXTLEN: begin
            if (desc_left > 0) desc_left = desc_left - 8'd1;
            if (b > desc_left) begin
               abort_section();
               return;
            end
            txt_left = b;
            if (b == 0) finish_text();
            else phase = P_TEXT;
         end
         P_TEXT: begin
            if (desc_left > 0) desc_left = desc_left - 8'd1;
            if (txt_left > 0) txt_left = txt_left - 8'd1;
            push_record(KIND_DESC, b, txt_left == 0, 1'b0);
            if (txt_left == 0) finish_text();
         end
         default: phase = P_IDLE;
      endcase
   endfunction

   // Drive one request after a random gap, hold it until accepted, then predict.
   task automatic send_byte(input logic [7:0] b, input logic first);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= first;
      do @(posedge clock); while (!req_tready);
      request_count++;
      predict_byte(b, first);
   endtask

   task automatic send_section(input byte_queue q);
      section_count++;
      foreach (q[i]) send_byte(q[i], i == 0);
   endtask

   // Append one event: header, then filler, short event, content and rating descriptors.
   function automatic void add_event(ref byte_queue ev, input int name_len, input int text_len,
                                     input bit with_short, input bit with_content,
                                     input bit with_rating, input bit with_other,
                                     input logic [15:0] id);
      byte_queue d;
      int n;
      if (with_other) begin
         n = $urandom_range(0, 3);
         d.push_back(8'h4a);
         d.push_back(8'(n));
         repeat (n) d.push_back(8'($urandom));
      end
      if (with_short) begin
         d.push_back(TAG_SHORT_EVT);
         d.push_back(8'(5 + name_len + text_len));
         repeat (3) d.push_back(8'($urandom));
         d.push_back(8'(name_len));
         repeat (name_len) d.push_back(8'($urandom));
         d.push_back(8'(text_len));
         repeat (text_len) d.push_back(8'($urandom));
      end
      if (with_content) begin
         n = $urandom_range(0, 4);
         d.push_back(TAG_CONTENT);
         d.push_back(8'(n));
         repeat (n) d.push_back(8'($urandom));
      end
      if (with_rating) begin
         n = $urandom_range(0, 1) ? 4 : $urandom_range(0, 8);
         d.push_back(TAG_RATING);
         d.push_back(8'(n));
         repeat (n) d.push_back(8'($urandom));
      end
      ev.push_back(id[15:8]);
      ev.push_back(id[7:0]);
      repeat (8) ev.push_back(8'($urandom));
      n = d.size();
      ev.push_back({4'($urandom), 4'(n >> 8)});
      ev.push_back(8'(n));
      foreach (d[i]) ev.push_back(d[i]);
   endfunction

   // Wrap the event bytes with table id, length, header and trailer.
   function automatic byte_queue wrap_section(input byte_queue ev);
      byte_queue s;
      int n;
      n = 11 + ev.size() + Trailer;
      s.push_back(8'h4e);
      s.push_back({4'hf, 4'(n >> 8)});
      s.push_back(8'(n));
      repeat (11) s.push_back(8'($urandom));
      foreach (ev[i]) s.push_back(ev[i]);
      repeat (Trailer) s.push_back(8'($urandom));
      return s;
   endfunction

   // Drop the request and hold off until every predicted record has come back.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (pending_records.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Check each record that the receiver takes against the oldest prediction.
   int stall_left = 0;
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         record_count++;
         if (pending_records.size() == 0) begin
            $display("%0t: unexpected record kind %0d", $time, rsp_tuser);
            mismatch_count++;
         end else begin
            want = pending_records.pop_front();
            if (want.kind == KIND_ERROR) error_count++;
            if (rsp_tuser != want.kind || rsp_tlast != want.section_done
                || rsp_tdata[15:0] != want.event_id || rsp_tdata[31:16] != want.start_mjd
                || rsp_tdata[50:32] != want.start_seconds
                || rsp_tdata[69:51] != want.duration_seconds
                || rsp_tdata[72:70] != want.run_state
                || rsp_tdata[73] != want.scrambled || rsp_tdata[81:74] != want.text_byte
                || rsp_tdata[89:82] != want.content_code
                || rsp_tdata[97:90] != want.age_rating
                || rsp_tdata[98] != want.text_last || rsp_tdata[103:99] != '0) begin
               $display("%0t: expected kind %0d last %0b data %h", $time, want.kind,
                        want.section_done,
                        {5'b0, want.text_last, want.age_rating, want.content_code,
                         want.text_byte, want.scrambled, want.run_state,
                         want.duration_seconds, want.start_seconds, want.start_mjd,
                         want.event_id});
               $display("%0t: actual   kind %0d last %0b data %h", $time, rsp_tuser,
                        rsp_tlast, rsp_tdata);
               mismatch_count++;
            end
         end
         stall_left = steady_flow ? 0 : $urandom_range(0, 3);
      end
      if (reset || stall_left > 0) begin
         if (!reset) stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Bad lengths, idle bytes, a dropped section and one event without filler descriptors.
   task automatic test_directed_cases();
      byte_queue ev;
      send_byte(8'h00, 1'b0);                   // idle bytes are ignored
      send_byte(8'hff, 1'b0);
      send_section('{8'h4e, 8'hff, 8'hff});     // length too large
      send_section('{8'h4e, 8'hf0, 8'h0f});     // length too small, no events
      send_section('{8'h4e, 8'hf0, 8'h40, 8'h00});   // dropped by the next start mark
      add_event(ev, 1, 0, 1, 1, 1, 0, 16'hffff);
      send_section(wrap_section(ev));
      wait_for_drain();
   endtask

   // Zero-length descriptor loop and a loop that overruns the section.
   task automatic test_event_bounds();
      byte_queue ev, s;
      add_event(ev, 0, 2, 1, 0, 0, 0, 16'h0000);
      s = wrap_section(ev);
      s[14 + 10] = 8'h0f;   // loop length far beyond the event region
      send_section(s);
      ev.delete();
      add_event(ev, 0, 0, 0, 0, 0, 0, 16'h1234);
      send_section(wrap_section(ev));
   endtask

   // Mostly well-formed sections with random content; some are corrupted or cut short.
   task automatic test_random_sections();
      byte_queue ev, s;
      int k;
      while (request_count < 240) begin
         steady_flow = ($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) send_byte(8'($urandom), 1'b0);
         ev.delete();
         repeat ($urandom_range(0, 6) == 0 ? 0 : $urandom_range(1, 3))
            add_event(ev, $urandom_range(0, 5), $urandom_range(0, 5), $urandom_range(0, 4) != 0,
                      $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                      16'($urandom));
         s = wrap_section(ev);
         k = $urandom_range(0, 9);
         if (k < 2) s[$urandom_range(1, s.size() - 1)] = 8'($urandom);
         else if (k == 2) s = s[0:$urandom_range(1, s.size() - 1)];
         send_section(s);
         // once, hold off until every outstanding record has come back
         if (section_count == 7) wait_for_drain();
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_event_bounds();
      test_random_sections();
      wait_for_drain();
      repeat (20) @(posedge clock);
      $display("Sent %0d requests in %0d sections; checked %0d records, %0d of them errors.",
               request_count, section_count, record_count, error_count);
      if (mismatch_count == 0 && pending_records.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
